### design/rcab_pkg.sv
`timescale 1ns / 1ps

package rcab_pkg;

    localparam int COORD_W     = 6;
    localparam int SUM_W       = COORD_W + 1;
    localparam int EXT_W       = COORD_W + 1;
    localparam int PIX_W       = 32;
    localparam int COPIED_W    = 13;
    localparam int QUEUE_DEPTH = 2;
    localparam int DEF_FRAME_WIDTH  = 64;
    localparam int DEF_FRAME_HEIGHT = 64;
    localparam logic [7:0] FULL_SCALE = 8'd255;

    typedef enum logic [1:0] {
        K_WRITE = 2'd0,
        K_READ  = 2'd1,
        K_COPY  = 2'd2
    } t_kind;

    // One classified request as it sits in the queue.
    typedef struct packed {
        t_kind                kind;
        logic [COORD_W-1:0]   pos_x;
        logic [COORD_W-1:0]   pos_y;
        logic [EXT_W-1:0]     len_x;
        logic [EXT_W-1:0]     len_y;
        logic [COORD_W-1:0]   dst_x;
        logic [COORD_W-1:0]   dst_y;
        logic                 blend;
        logic [PIX_W-1:0]     pixel;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel_out;
        logic [COPIED_W-1:0] pixels_copied;
        logic                dest_clipped;
    } t_res;

    // Exact n / 255 for n up to 255 * 255.
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] t;
        t = {1'b0, n} + {9'd0, n[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

### design/rcab_front.sv
`timescale 1ns / 1ps

module rcab_front
    import rcab_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_kind,
    input  logic [COORD_W-1:0] i_pos_x,
    input  logic [COORD_W-1:0] i_pos_y,
    input  logic [COORD_W-1:0] i_end_x,
    input  logic [COORD_W-1:0] i_end_y,
    input  logic [COORD_W-1:0] i_dst_x,
    input  logic [COORD_W-1:0] i_dst_y,
    input  logic               i_blend,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic               i_q_full,
    output logic               o_q_push,
    output t_cmd               o_q_cmd
);

    // Last coordinate the walk may reach in each dimension.
    localparam int XMAX_I = (FRAME_WIDTH  > 64) ? 63 : FRAME_WIDTH  - 1;
    localparam int YMAX_I = (FRAME_HEIGHT > 64) ? 63 : FRAME_HEIGHT - 1;
    localparam logic [COORD_W-1:0] XMAX = COORD_W'(XMAX_I);
    localparam logic [COORD_W-1:0] YMAX = COORD_W'(YMAX_I);

    logic               r_valid;
    t_cmd               r_cmd;
    t_cmd               n_cmd;
    logic [COORD_W-1:0] stop_x;
    logic [COORD_W-1:0] stop_y;

    function automatic logic [EXT_W-1:0] extent(
        input logic [COORD_W-1:0] start,
        input logic [COORD_W-1:0] last,
        input logic [COORD_W-1:0] stop,
        input logic [COORD_W-1:0] lim
    );
        if (start > lim || start > last) begin
            return EXT_W'(1);
        end
        return {1'b0, stop} - {1'b0, start} + EXT_W'(1);
    endfunction

    assign stop_x = (i_end_x < XMAX) ? i_end_x : XMAX;
    assign stop_y = (i_end_y < YMAX) ? i_end_y : YMAX;

    always_comb begin
        n_cmd       = '0;
        n_cmd.kind  = t_kind'(i_kind);
        n_cmd.pos_x = i_pos_x;
        n_cmd.pos_y = i_pos_y;
        n_cmd.len_x = extent(i_pos_x, i_end_x, stop_x, XMAX);
        n_cmd.len_y = extent(i_pos_y, i_end_y, stop_y, YMAX);
        n_cmd.dst_x = i_dst_x;
        n_cmd.dst_y = i_dst_y;
        n_cmd.blend = i_blend;
        n_cmd.pixel = i_pixel;
    end

    assign o_ready  = !r_valid || !i_q_full;
    assign o_q_push = r_valid && !i_q_full;
    assign o_q_cmd  = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_q_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### design/rcab_fifo.sv
`timescale 1ns / 1ps

module rcab_fifo
    import rcab_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [PTR_W:0]   r_count;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_full       = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= bump(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= bump(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (PTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

### design/rcab_back.sv
`timescale 1ns / 1ps

module rcab_back
    import rcab_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_head i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_res    o_res
);

    // Coordinates never exceed 126, so only that much of the frame is reachable.
    localparam int XW_I = (FRAME_WIDTH > 128) ? 7 : $clog2(FRAME_WIDTH);
    localparam int YW_I = (FRAME_HEIGHT > 128) ? 7 : $clog2(FRAME_HEIGHT);
    localparam int XW   = (XW_I < 1) ? 1 : XW_I;
    localparam int YW   = (YW_I < 1) ? 1 : YW_I;
    localparam int AW   = XW + YW;
    localparam int DEPTH = 1 << AW;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_EXEC = 8'b0000_0010,
        S_RDW  = 8'b0000_0100,
        S_SRC  = 8'b0000_1000,
        S_DST  = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_WR   = 8'b0100_0000,
        S_RES  = 8'b1000_0000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    t_cmd                r_cmd;
    logic [COORD_W-1:0]  r_wx;
    logic [COORD_W-1:0]  r_wy;
    logic [COPIED_W-1:0] r_count;
    logic                r_clip;
    logic                r_src_ok;
    logic                r_dst_ok;
    logic [SUM_W-1:0]    r_tx;
    logic [SUM_W-1:0]    r_ty;
    logic [PIX_W-1:0]    r_src;
    logic [7:0]          r_dst_a;
    logic [15:0]         r_prod [3];
    logic [PIX_W-1:0]    r_rd_data;
    logic [PIX_W-1:0]    r_mem [DEPTH];
    t_res                r_res;
    logic                r_out_valid;
    t_res                r_out;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [PIX_W-1:0]    wr_data;
    logic [SUM_W-1:0]    px_ext;
    logic [SUM_W-1:0]    py_ext;
    logic [SUM_W-1:0]    sx;
    logic [SUM_W-1:0]    sy;
    logic [SUM_W-1:0]    tx;
    logic [SUM_W-1:0]    ty;
    logic                last_x;
    logic                last_y;
    logic                out_free;
    logic [PIX_W-1:0]    blended;

    function automatic logic in_frame(input logic [SUM_W-1:0] x, input logic [SUM_W-1:0] y);
        return ({{(32 - SUM_W){1'b0}}, x} < 32'(FRAME_WIDTH)) &&
               ({{(32 - SUM_W){1'b0}}, y} < 32'(FRAME_HEIGHT));
    endfunction

    function automatic logic [AW-1:0] addr_of(
        input logic [SUM_W-1:0] x,
        input logic [SUM_W-1:0] y
    );
        return {y[YW-1:0], x[XW-1:0]};
    endfunction

    assign px_ext   = {1'b0, r_cmd.pos_x};
    assign py_ext   = {1'b0, r_cmd.pos_y};
    assign sx       = px_ext + {1'b0, r_wx};
    assign sy       = py_ext + {1'b0, r_wy};
    assign tx       = {1'b0, r_cmd.dst_x} + {1'b0, r_wx};
    assign ty       = {1'b0, r_cmd.dst_y} + {1'b0, r_wy};
    assign last_x   = (r_wx == COORD_W'(r_cmd.len_x - EXT_W'(1)));
    assign last_y   = (r_wy == COORD_W'(r_cmd.len_y - EXT_W'(1)));
    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = (r_state == S_IDLE) && i_head.valid;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    assign blended = {r_dst_a, div255(r_prod[2]), div255(r_prod[1]), div255(r_prod[0])};

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = addr_of(px_ext, py_ext);
        wr_en   = 1'b0;
        wr_addr = addr_of(px_ext, py_ext);
        wr_data = r_cmd.pixel;
        unique case (r_state)
            S_EXEC: begin
                rd_en = (r_cmd.kind == K_READ);
                wr_en = (r_cmd.kind == K_WRITE) && in_frame(px_ext, py_ext);
            end
            S_SRC: begin
                rd_en   = 1'b1;
                rd_addr = addr_of(sx, sy);
            end
            S_DST: begin
                rd_en   = 1'b1;
                rd_addr = addr_of(r_tx, r_ty);
            end
            S_WR: begin
                wr_en   = r_dst_ok;
                wr_addr = addr_of(r_tx, r_ty);
                wr_data = r_cmd.blend ? blended : r_src;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_head.valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd.kind)
                    K_READ:  n_state = S_RDW;
                    K_COPY:  n_state = S_SRC;
                    default: n_state = S_RES;
                endcase
            end
            S_RDW: n_state = S_RES;
            S_SRC: n_state = S_DST;
            S_DST: n_state = S_MUL;
            S_MUL: n_state = S_WR;
            S_WR:  n_state = (last_x && last_y) ? S_RES : S_SRC;
            S_RES: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_RES && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RES && out_free) begin
            r_out <= r_res;
        end
        unique case (r_state)
            S_IDLE: begin
                r_cmd   <= i_head.cmd;
                r_wx    <= '0;
                r_wy    <= '0;
                r_count <= '0;
                r_clip  <= 1'b0;
                r_res   <= '0;
            end
            S_RDW: begin
                r_res.pixel_out <= in_frame(px_ext, py_ext) ? r_rd_data : '0;
            end
            S_SRC: begin
                r_src_ok <= in_frame(sx, sy);
                r_dst_ok <= in_frame(tx, ty);
                r_tx     <= tx;
                r_ty     <= ty;
            end
            S_DST: begin
                r_src <= r_src_ok ? r_rd_data : '0;
            end
            S_MUL: begin
                // Destination pixel is on the read port now.
                r_dst_a <= r_rd_data[31:24];
                for (int c = 0; c < 3; c++) begin
                    r_prod[c] <= 16'({8'd0, r_src[8*c +: 8]} * {8'd0, r_src[31:24]}) +
                                 16'({8'd0, r_rd_data[8*c +: 8]} *
                                     {8'd0, FULL_SCALE - r_src[31:24]});
                end
            end
            S_WR: begin
                r_count <= r_count + COPIED_W'(1);
                r_clip  <= r_clip || !r_dst_ok;
                r_res.pixels_copied <= r_count + COPIED_W'(1);
                r_res.dest_clipped  <= r_clip || !r_dst_ok;
                if (last_x) begin
                    r_wx <= '0;
                    r_wy <= r_wy + COORD_W'(1);
                end else begin
                    r_wx <= r_wx + COORD_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

### design/region_copy_alpha_blend_engine.sv
`timescale 1ns / 1ps

// Region copy and alpha blend engine over a FRAME_WIDTH x FRAME_HEIGHT frame
// store of 32-bit RGBA pixels (r in bits 7:0, g 15:8, b 23:16, a 31:24).
// Requests arrive on the s channel; tuser carries the kind (write pixel,
// read pixel or copy region) and tdata the coordinates, blend flag and pixel.
// Every request returns exactly one result on the m channel, in order.
// A front stage registers each request and works out the copy extents, a
// two-entry queue holds classified requests, and a back sequencer executes
// them against a single-port-read, single-port-write frame memory.
// In the back a write passes the execute and result states, a read adds a
// read-wait state, and a copy runs source read, destination read, multiply and
// write states per pixel: two reads share the one memory read port. Requests
// pass the front register and the queue on their way to the back.
// Requests are taken while the front register or queue has room, so the
// sender keeps going while a copy runs or while a result waits.
// Reset clears all control state; the frame store itself is not cleared and
// a pixel must be written before it is read. If the receiver stalls, the
// result holds in the output register and the back waits for it to leave.

module region_copy_alpha_blend_engine
    import rcab_pkg::*;
#(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // kind[1:0]
    input  logic [1:0]  i_s_tuser,
    // pos_x[5:0], pos_y[11:6], end_x[17:12], end_y[23:18], dst_x[29:24],
    // dst_y[35:30], blend[36], pixel_in[68:37], zero fill [71:69]
    input  logic [71:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // pixel_out[31:0], pixels_copied[44:32], dest_clipped[45], zero fill [47:46]
    output logic [47:0] o_m_tdata
);

    logic    q_full;
    logic    q_push;
    t_cmd    q_cmd;
    logic    q_pop;
    t_q_head q_head;
    t_res    res;

    rcab_front #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_kind   (i_s_tuser),
        .i_pos_x  (i_s_tdata[5:0]),
        .i_pos_y  (i_s_tdata[11:6]),
        .i_end_x  (i_s_tdata[17:12]),
        .i_end_y  (i_s_tdata[23:18]),
        .i_dst_x  (i_s_tdata[29:24]),
        .i_dst_y  (i_s_tdata[35:30]),
        .i_blend  (i_s_tdata[36]),
        .i_pixel  (i_s_tdata[68:37]),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_cmd)
    );

    rcab_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    rcab_back #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (q_head),
        .o_pop   (q_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (res)
    );

    assign o_m_tdata = {2'b00, res.dest_clipped, res.pixels_copied, res.pixel_out};

    // The front never pushes a request into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("request pushed into full queue");

    // The back only pops when a request is waiting.
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_head.valid)
        else $error("queue popped while empty");

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

### sim/region_copy_alpha_blend_engine_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the region copy and alpha blend engine.
//
// The bench keeps its own copy of the 64 x 64 frame store and predicts every
// result when a request is accepted on the s channel. A checking process
// compares each result on the m channel, field by field, with the oldest
// prediction still pending.
//
// The frame store is not cleared by reset, and no pixel may be read before it
// is written. So the first test fills the frame: it writes the top row pixel
// by pixel and then copies the filled rows downward, doubling the filled band
// each time. After that, any read, copy or blend is legal. Reads, copies and
// blends cover the whole frame, clipping included.
//
// Both sides draw a random wait for every request and every result. The waits
// are switched off for some stretches of the run, so the block also sees
// back-to-back traffic. A watchdog budget grows with the worst-case cost of
// each accepted request and ends the run if the block hangs.

module region_copy_alpha_blend_engine_test;
    import rcab_pkg::*;

    localparam int FRAME_W         = DEF_FRAME_WIDTH;
    localparam int FRAME_H         = DEF_FRAME_HEIGHT;
    localparam int FRAME_PIXELS    = FRAME_W * FRAME_H;
    localparam int RANDOM_REQUESTS = 1160;
    localparam int MAX_WAIT        = 9;
    localparam int DRAIN_CYCLES    = 16;
    localparam int RESET_CYCLES    = 7;

    // Kind code 3 has no operation. The block must still answer it with a
    // result that is all zeros.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // One request as the bench builds it. The kind travels on tuser, and the
    // other fields go into tdata with pos_x in the lowest bits.
    typedef struct packed {
        logic [1:0]         kind;
        logic [PIX_W-1:0]   pixel;
        logic               blend;
        logic [COORD_W-1:0] dst_y;
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_x;
    } t_blit_req;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // kind[1:0]
    logic [1:0]  s_tuser  = '0;
    // pos_x[5:0], pos_y[11:6], end_x[17:12], end_y[23:18], dst_x[29:24],
    // dst_y[35:30], blend[36], pixel_in[68:37], zero fill [71:69]
    logic [71:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // pixel_out[31:0], pixels_copied[44:32], dest_clipped[45], zero fill [47:46]
    logic [47:0] m_tdata;

    // The bench's copy of the frame store, indexed y * FRAME_W + x.
    logic [PIX_W-1:0] frame_mirror [FRAME_PIXELS];
    t_res             pending_results [$];

    bit          send_idle = 1'b1;
    bit          recv_idle = 1'b1;
    int unsigned fail_count   = 0;
    int unsigned results_seen = 0;
    longint      cycle_count  = 0;
    longint      cycle_budget = 2000;

    // Counts for the closing summary.
    int unsigned n_writes = 0;
    int unsigned n_reads  = 0;
    int unsigned n_copies = 0;
    int unsigned n_unused = 0;
    int unsigned n_clipped = 0;
    longint      pixels_moved = 0;

    region_copy_alpha_blend_engine dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tuser  (s_tuser),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // This is the number of elements that a copy visits in one dimension. The
    // walk runs from start up to the end or the frame edge, whichever comes
    // first. If the start is past the end or outside the frame, the walk
    // still visits one element.
    function automatic int copy_span(input int start, input int last, input int size);
        int stop;
        if (start >= size || start > last)
            return 1;
        stop = (last < size - 1) ? last : size - 1;
        return stop - start + 1;
    endfunction

    // Each color channel takes (src * a + dst * (255 - a)) / 255, where a is
    // the alpha of the source. The destination keeps its own alpha.
    function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] dst,
                                                    input logic [PIX_W-1:0] src);
        int alpha;
        int full;
        logic [PIX_W-1:0] mixed;
        full  = int'(FULL_SCALE);
        alpha = int'(src[31:24]);
        mixed = dst;
        for (int c = 0; c < 3; c++)
            mixed[8*c +: 8] = 8'((int'(src[8*c +: 8]) * alpha +
                                  int'(dst[8*c +: 8]) * (full - alpha)) / full);
        return mixed;
    endfunction

    // This applies one request to the frame copy and returns the result the
    // block must give. Pixels are handled one at a time in raster order, so a
    // copy that overlaps its own destination reads the pixels it has already
    // written.
    function automatic t_res predict_blit(input t_blit_req r);
        t_res res;
        int nx;
        int ny;
        int tx;
        int ty;
        logic [PIX_W-1:0] src;
        res = '0;
        case (r.kind)
            K_WRITE: frame_mirror[int'(r.pos_y) * FRAME_W + int'(r.pos_x)] = r.pixel;
            K_READ:  res.pixel_out = frame_mirror[int'(r.pos_y) * FRAME_W + int'(r.pos_x)];
            K_COPY: begin
                nx = copy_span(int'(r.pos_x), int'(r.end_x), FRAME_W);
                ny = copy_span(int'(r.pos_y), int'(r.end_y), FRAME_H);
                for (int wy = 0; wy < ny; wy++) begin
                    for (int wx = 0; wx < nx; wx++) begin
                        src = frame_mirror[(int'(r.pos_y) + wy) * FRAME_W +
                                           int'(r.pos_x) + wx];
                        tx  = int'(r.dst_x) + wx;
                        ty  = int'(r.dst_y) + wy;
                        res.pixels_copied++;
                        if (tx >= FRAME_W || ty >= FRAME_H)
                            res.dest_clipped = 1'b1;
                        else if (r.blend)
                            frame_mirror[ty * FRAME_W + tx] =
                                blend_over(frame_mirror[ty * FRAME_W + tx], src);
                        else
                            frame_mirror[ty * FRAME_W + tx] = src;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // This task sends one request. It starts at a falling edge and returns at
    // the falling edge after the request is taken. Valid is only lowered when
    // a wait is drawn, so back-to-back requests keep it high.
    task automatic send_request(input t_blit_req r);
        int   gap;
        t_res want;
        gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {3'b000, r.pixel, r.blend, r.dst_y, r.dst_x,
                     r.end_y, r.end_x, r.pos_y, r.pos_x};
        do @(posedge clk); while (!s_tready);

        want = predict_blit(r);
        pending_results.push_back(want);
        // Allow several times the worst case: the longest gap on each side
        // plus the back end walking every pixel.
        cycle_budget += 100 + 16 * longint'(want.pixels_copied);
        case (r.kind)
            K_WRITE: n_writes++;
            K_READ:  n_reads++;
            K_COPY: begin
                n_copies++;
                pixels_moved += want.pixels_copied;
                if (want.dest_clipped)
                    n_clipped++;
            end
            default: n_unused++;
        endcase
        @(negedge clk);
    endtask

    function automatic t_blit_req make_req(input logic [1:0] kind,
                                           input int px, input int py,
                                           input int ex, input int ey,
                                           input int dx, input int dy,
                                           input logic blend,
                                           input logic [PIX_W-1:0] pixel);
        t_blit_req r;
        r.kind  = kind;
        r.pos_x = COORD_W'(px);
        r.pos_y = COORD_W'(py);
        r.end_x = COORD_W'(ex);
        r.end_y = COORD_W'(ey);
        r.dst_x = COORD_W'(dx);
        r.dst_y = COORD_W'(dy);
        r.blend = blend;
        r.pixel = pixel;
        return r;
    endfunction

    // Transparent and opaque alphas come up often, so both ends of the blend
    // are tested.
    function automatic logic [PIX_W-1:0] random_pixel();
        logic [7:0] alpha;
        case ($urandom_range(0, 3))
            0:       alpha = 8'h00;
            1:       alpha = 8'hFF;
            default: alpha = 8'($urandom);
        endcase
        return {alpha, 24'($urandom)};
    endfunction

    // Every field gets a random value, even one that the kind ignores, so
    // that all input bits toggle.
    function automatic t_blit_req random_fields();
        t_blit_req r;
        r.kind  = K_READ;
        r.pos_x = COORD_W'($urandom);
        r.pos_y = COORD_W'($urandom);
        r.end_x = COORD_W'($urandom);
        r.end_y = COORD_W'($urandom);
        r.dst_x = COORD_W'($urandom);
        r.dst_y = COORD_W'($urandom);
        r.blend = 1'($urandom);
        r.pixel = random_pixel();
        return r;
    endfunction

    // Each side idles most of the time, but some stretches run at full rate.
    task automatic shuffle_idle();
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // This process draws a stall for every result, then holds ready high
    // until a result is taken.
    initial begin : result_taker
        int stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = recv_idle ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
        end
    end

    task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
        if (want !== got) begin
            $display("%0t: result %0d %s expected %h actual %h",
                     $time, results_seen, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_res want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result %0d arrived with nothing pending, expected none actual %h",
                         $time, results_seen, m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("pixel_out", want.pixel_out, m_tdata[31:0]);
                check_field("pixels_copied", PIX_W'(want.pixels_copied),
                            PIX_W'(m_tdata[44:32]));
                check_field("dest_clipped", PIX_W'(want.dest_clipped), PIX_W'(m_tdata[45]));
            end
            results_seen++;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > cycle_budget) begin
            $display("%0t: timeout after %0d cycles, %0d results still pending",
                     $time, cycle_count, pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // This test fills the frame so that later reads and copies touch only
    // pixels that were written. It writes the top row pixel by pixel, then
    // copies the filled rows below themselves, doubling the band each time
    // until every row holds data. The first and last pixels of the top row
    // are all zeros and all ones.
    task automatic test_preload_frame();
        t_blit_req r;
        shuffle_idle();
        for (int x = 0; x < FRAME_W; x++) begin
            r       = random_fields();
            r.kind  = K_WRITE;
            r.pos_x = COORD_W'(x);
            r.pos_y = '0;
            if (x == 0)
                r.pixel = '0;
            else if (x == FRAME_W - 1)
                r.pixel = '1;
            send_request(r);
        end
        for (int h = 1; h < FRAME_H; h = h * 2)
            send_request(make_req(K_COPY, 0, 0, FRAME_W - 1, h - 1, 0, h, 1'b0, '0));
    endtask

    // This test covers the frame corners, the single-pixel walk, both ends of
    // the alpha range, overlapping copies, full-frame copies, clipping and the
    // unused kind code.
    task automatic test_directed_edges();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        send_request(make_req(K_READ, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        send_request(make_req(K_READ, 63, 63, 63, 63, 63, 63, 1'b1, '1));
        send_request(make_req(K_WRITE, 63, 63, 0, 0, 0, 0, 1'b0, 32'hFFFF_FFFF));
        send_request(make_req(K_WRITE, 0, 0, 0, 0, 0, 0, 1'b0, 32'h0000_0000));
        // A copy of one pixel from the far corner onto the origin.
        send_request(make_req(K_COPY, 63, 63, 63, 63, 0, 0, 1'b0, '0));
        send_request(make_req(K_READ, 0, 0, 0, 0, 0, 0, 1'b0, '0));
        // When the start is past the end in both dimensions, the copy visits
        // exactly one pixel.
        send_request(make_req(K_COPY, 40, 50, 10, 20, 5, 5, 1'b0, '0));
        send_request(make_req(K_READ, 5, 5, 0, 0, 0, 0, 1'b0, '0));
        // Blend a source with alpha 0, 255 and a middle value.
        send_request(make_req(K_WRITE, 2, 2, 0, 0, 0, 0, 1'b0, 32'h00A5_5A3C));
        send_request(make_req(K_COPY, 2, 2, 2, 2, 3, 3, 1'b1, '0));
        send_request(make_req(K_READ, 3, 3, 0, 0, 0, 0, 1'b0, '0));
        send_request(make_req(K_WRITE, 2, 2, 0, 0, 0, 0, 1'b0, 32'hFF12_34F0));
        send_request(make_req(K_COPY, 2, 2, 2, 2, 3, 3, 1'b1, '0));
        send_request(make_req(K_READ, 3, 3, 0, 0, 0, 0, 1'b0, '0));
        send_request(make_req(K_WRITE, 2, 2, 0, 0, 0, 0, 1'b0, 32'h80FF_0080));
        send_request(make_req(K_COPY, 2, 2, 2, 2, 3, 3, 1'b1, '0));
        send_request(make_req(K_READ, 3, 3, 0, 0, 0, 0, 1'b0, '0));
        // Copy a row one pixel to the right. Each write feeds the next read,
        // so the first pixel spreads along the whole row.
        send_request(make_req(K_COPY, 0, 10, 20, 10, 1, 10, 1'b0, '0));
        send_request(make_req(K_READ, 21, 10, 0, 0, 0, 0, 1'b0, '0));
        // Blend the whole frame onto itself, then copy it to the last corner
        // so that all pixels but one are clipped.
        send_request(make_req(K_COPY, 0, 0, 63, 63, 0, 0, 1'b1, '0));
        send_request(make_req(K_COPY, 0, 0, 63, 63, 63, 63, 1'b0, '0));
        send_request(make_req(K_COPY, 60, 60, 63, 63, 62, 0, 1'b1, '0));
        send_request(make_req(KIND_UNUSED, 63, 63, 63, 63, 63, 63, 1'b1, '1));
        send_request(make_req(KIND_UNUSED, 0, 0, 0, 0, 0, 0, 1'b0, '0));
    endtask

    // This test sends a random mix of requests. Most copies are small
    // rectangles, some are long strips, and a few use random corners that can
    // cover most of the frame. Half the copies land near their source so the
    // regions overlap.
    task automatic test_random_traffic();
        t_blit_req r;
        int pick;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 64 == 0)
                shuffle_idle();
            r    = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                r.kind = K_WRITE;
            end else if (pick < 60) begin
                r.kind = K_READ;
            end else if (pick < 97) begin
                r.kind = K_COPY;
                pick   = $urandom_range(0, 19);
                if (pick >= 4) begin
                    // Small box. Near the edge the end can wrap below the start.
                    r.end_x = r.pos_x + COORD_W'($urandom_range(0, 7));
                    r.end_y = r.pos_y + COORD_W'($urandom_range(0, 7));
                end else if (pick >= 2) begin
                    r.end_x = COORD_W'($urandom_range(int'(r.pos_x), FRAME_W - 1));
                    r.end_y = r.pos_y + COORD_W'($urandom_range(0, 3));
                end else if (pick == 1) begin
                    r.end_x = r.pos_x + COORD_W'($urandom_range(0, 3));
                    r.end_y = COORD_W'($urandom_range(int'(r.pos_y), FRAME_H - 1));
                end
                if ($urandom_range(0, 1) == 1) begin
                    r.dst_x = r.pos_x + COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
                    r.dst_y = r.pos_y + COORD_W'($urandom_range(0, 4)) - COORD_W'(2);
                end
            end else begin
                r.kind = KIND_UNUSED;
            end
            send_request(r);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_preload_frame();
        test_directed_edges();
        test_random_traffic();
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d writes, %0d reads, %0d unused-kind requests and %0d copies",
                 n_writes, n_reads, n_unused, n_copies);
        $display("Copies walked %0d pixels; %0d of them dropped pixels at the frame edge",
                 pixels_moved, n_clipped);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
